[rtl/tfcp_pkg.sv]
package tfcp_pkg;

  // Parse phase, one-hot.
  typedef enum logic [3:0] {
    PH_LETTER = 4'b0001,
    PH_FIRST  = 4'b0010,
    PH_WHOLE  = 4'b0100,
    PH_FRAC   = 4'b1000
  } tfcp_phase_e;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_S = 2'd1,
    DIR_W = 2'd2,
    DIR_E = 2'd3
  } tfcp_dir_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_END       = 3'd1,
    ST_BAD_TOKEN = 3'd2,
    ST_NO_ANGLE  = 3'd3,
    ST_RANGE     = 3'd4
  } tfcp_status_e;

  localparam int unsigned AccW = 10;
  localparam int unsigned LatW = 8;
  localparam int unsigned LonW = 9;

  localparam logic [AccW-1:0] AccMax  = 10'd1023;
  localparam logic [AccW-1:0] LatBase = 10'd90;
  localparam logic [AccW-1:0] LonBase = 10'd360;

  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpN    = 8'h4E;
  localparam logic [7:0] ChLoN    = 8'h6E;
  localparam logic [7:0] ChUpS    = 8'h53;
  localparam logic [7:0] ChLoS    = 8'h73;
  localparam logic [7:0] ChUpW    = 8'h57;
  localparam logic [7:0] ChLoW    = 8'h77;
  localparam logic [7:0] ChUpE    = 8'h45;
  localparam logic [7:0] ChLoE    = 8'h65;

  typedef struct packed {
    tfcp_phase_e     phase;
    tfcp_dir_e       dir;
    logic [AccW-1:0] accum;
    logic            lat_valid;
    logic [LatW-1:0] lat_value;
    logic            lon_valid;
    logic [LonW-1:0] lon_value;
    tfcp_status_e    err;
  } tfcp_state_t;

  typedef struct packed {
    tfcp_status_e    status;
    logic [LatW-1:0] colatitude;
    logic [LonW-1:0] longitude;
  } tfcp_result_t;

  localparam tfcp_state_t TfcpStateRst = '{
    phase:     PH_LETTER,
    dir:       DIR_N,
    accum:     '0,
    lat_valid: 1'b0,
    lat_value: '0,
    lon_valid: 1'b0,
    lon_value: '0,
    err:       ST_OK
  };

endpackage

[rtl/tile_filename_coord_parser_unit.sv]
// Tile path coordinate parser.
// Input channel: one path byte per word on ch_i, with last_i marking the final
// byte, under in_valid_i / in_ready_o. Output channel: one word per path with
// status_o, colatitude_o and longitude_o under out_valid_o / out_ready_i.
// A slash or backslash restarts parsing; the last path component decides the
// result. Colatitude and longitude read as zero when status_o is not ok.
// Throughput is one byte per cycle unless a waiting result is stalled. The parse
// state is updated in the cycle a byte is taken, and the result for a path
// appears in the output register in the cycle after its last byte is taken.
// When the receiver stalls, the result waits in the output register and input
// is still taken as long as that register is free or being emptied; a second
// result is held back until the first one leaves.
// Reset clears the parse state and the output valid flag; the block is ready
// to take bytes in the first cycle after reset.
module tile_filename_coord_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] ch_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] colatitude_o,
  output logic [8:0] longitude_o
);
  import tfcp_pkg::*;

  tfcp_state_t  state_q;
  tfcp_state_t  state_d;
  tfcp_result_t res_d;
  tfcp_result_t res_q;
  logic         out_valid_q;
  logic         in_fire;

  tfcp_step u_step (
    .state_i  (state_q),
    .ch_i     (ch_i),
    .last_i   (last_i),
    .state_o  (state_d),
    .result_o (res_d)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= TfcpStateRst;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && last_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign colatitude_o = res_q.colatitude;
  assign longitude_o  = res_q.longitude;

endmodule

[rtl/tfcp_step.sv]
module tfcp_step (
  input  tfcp_pkg::tfcp_state_t  state_i,
  input  logic [7:0]             ch_i,
  input  logic                   last_i,
  output tfcp_pkg::tfcp_state_t  state_o,
  output tfcp_pkg::tfcp_result_t result_o
);
  import tfcp_pkg::*;

  function automatic tfcp_state_t take_letter(tfcp_state_t s, logic [7:0] c);
    tfcp_state_t r;
    r = s;
    r.phase = PH_FIRST;
    case (c)
      ChUpN, ChLoN: r.dir = DIR_N;
      ChUpS, ChLoS: r.dir = DIR_S;
      ChUpW, ChLoW: r.dir = DIR_W;
      ChUpE, ChLoE: r.dir = DIR_E;
      default: begin
        r.phase = s.phase;
        r.err   = ST_BAD_TOKEN;
      end
    endcase
    return r;
  endfunction

  function automatic tfcp_state_t close_num(tfcp_state_t s);
    tfcp_state_t r;
    r = s;
    r.phase = PH_LETTER;
    if (s.dir == DIR_N || s.dir == DIR_S) begin
      if (s.accum > LatBase) begin
        r.err = ST_RANGE;
      end else begin
        r.lat_value = (s.dir == DIR_N) ? LatW'(LatBase - s.accum)
                                       : LatW'(LatBase + s.accum);
        r.lat_valid = 1'b1;
      end
    end else begin
      if (s.accum >= LonBase) begin
        r.err = ST_RANGE;
      end else begin
        r.lon_value = (s.dir == DIR_W) ? LonW'(LonBase - s.accum)
                                       : s.accum[LonW-1:0];
        r.lon_valid = 1'b1;
      end
    end
    return r;
  endfunction

  tfcp_state_t     fed;
  tfcp_state_t     fin;
  logic            is_sep;
  logic            is_digit;
  logic            is_point;
  logic [13:0]     acc_next;
  logic            open_path;

  assign is_sep   = (ch_i == ChSlash) || (ch_i == ChBslash);
  assign is_digit = (ch_i >= ChZero) && (ch_i <= ChNine);
  assign is_point = (ch_i == ChDot) || (ch_i == ChComma);
  // Times ten as two shifted adds, then the new digit.
  assign acc_next = 14'({state_i.accum, 3'b000}) + 14'({state_i.accum, 1'b0})
                  + 14'(ch_i[3:0]);
  assign open_path = (state_i.err == ST_OK) && !(state_i.lat_valid && state_i.lon_valid);

  always_comb begin
    fed = state_i;
    if (is_sep) begin
      fed = TfcpStateRst;
    end else if (open_path) begin
      case (state_i.phase)
        PH_LETTER: fed = take_letter(state_i, ch_i);
        PH_FIRST: begin
          if (is_digit) begin
            fed.accum = AccW'(ch_i[3:0]);
            fed.phase = PH_WHOLE;
          end else begin
            fed.err = ST_NO_ANGLE;
          end
        end
        PH_WHOLE, PH_FRAC: begin
          if (is_digit) begin
            if (state_i.phase == PH_WHOLE) begin
              fed.accum = (acc_next > 14'(AccMax)) ? AccMax : acc_next[AccW-1:0];
            end
          end else if (is_point && state_i.phase == PH_WHOLE) begin
            fed.phase = PH_FRAC;
          end else begin
            // The byte that ends a number is read again as a direction letter.
            fed = close_num(state_i);
            if (fed.err == ST_OK && !(fed.lat_valid && fed.lon_valid)) begin
              fed = take_letter(fed, ch_i);
            end
          end
        end
        default: fed = TfcpStateRst;
      endcase
    end

    fin = fed;
    if (fin.err == ST_OK && !(fin.lat_valid && fin.lon_valid)) begin
      if (fin.phase == PH_WHOLE || fin.phase == PH_FRAC) begin
        fin = close_num(fin);
      end
      if (fin.err == ST_OK && !(fin.lat_valid && fin.lon_valid)) begin
        fin.err = ST_END;
      end
    end
  end

  // The path ends here: report, then start over from the reset state.
  assign state_o = last_i ? TfcpStateRst : fed;

  assign result_o.status     = fin.err;
  assign result_o.colatitude = (fin.err == ST_OK) ? fin.lat_value : '0;
  assign result_o.longitude  = (fin.err == ST_OK) ? fin.lon_value : '0;

endmodule

[rtl/tfcp_checker.sv]
module tfcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] status_i,
  input logic [7:0] colatitude_i,
  input logic [8:0] longitude_i
);
  import tfcp_pkg::*;

  // A free output register never blocks input.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while the output register is empty");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(colatitude_i) && $stable(longitude_i))
    else $error("stalled result word changed");

  // A new result only follows a taken final byte.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && last_i))
    else $error("result word without a final byte");

  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_OK |-> colatitude_i <= 8'd180 && longitude_i <= 9'd360)
    else $error("angle out of range on an ok result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> colatitude_i == '0 && longitude_i == '0)
    else $error("angles not zero on an error result");

endmodule

bind tile_filename_coord_parser_unit tfcp_checker u_tfcp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_i   (in_ready_o),
  .last_i       (last_i),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_i     (status_o),
  .colatitude_i (colatitude_o),
  .longitude_i  (longitude_o)
);

[tb/tfcp_coord_checker.sv]
module tfcp_coord_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  ch_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  colatitude_i,
  input  logic [8:0]  longitude_i,
  output int unsigned pending_o,
  output int unsigned mismatches_o
);
  import tfcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow parse state of the block.
  tfcp_phase_e     cur_phase;
  tfcp_dir_e       cur_dir;
  logic [AccW-1:0] degrees_acc;
  logic            lat_known;
  logic [LatW-1:0] colat_deg;
  logic            lon_known;
  logic [LonW-1:0] lon_deg;
  tfcp_status_e    first_err;

  tfcp_result_t expected_coords[$];
  int unsigned  mismatch_count = 0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic bit both_known();
    return lat_known && lon_known;
  endfunction

  task automatic coord_clear();
    cur_phase   = PH_LETTER;
    cur_dir     = DIR_N;
    degrees_acc = '0;
    lat_known   = 1'b0;
    colat_deg   = '0;
    lon_known   = 1'b0;
    lon_deg     = '0;
    first_err   = ST_OK;
  endtask

  task automatic take_letter(input logic [7:0] c);
    bit hit;
    hit = 1'b1;
    case (c)
      ChUpN, ChLoN: cur_dir = DIR_N;
      ChUpS, ChLoS: cur_dir = DIR_S;
      ChUpW, ChLoW: cur_dir = DIR_W;
      ChUpE, ChLoE: cur_dir = DIR_E;
      default: hit = 1'b0;
    endcase
    if (hit) begin
      cur_phase = PH_FIRST;
    end else begin
      first_err = ST_BAD_TOKEN;
    end
  endtask

  task automatic close_angle();
    logic [AccW-1:0] val;
    cur_phase = PH_LETTER;
    if (cur_dir == DIR_N || cur_dir == DIR_S) begin
      if (degrees_acc > LatBase) begin
        first_err = ST_RANGE;
      end else begin
        val = (cur_dir == DIR_N) ? LatBase - degrees_acc : LatBase + degrees_acc;
        colat_deg = val[LatW-1:0];
        lat_known = 1'b1;
      end
    end else begin
      if (degrees_acc >= LonBase) begin
        first_err = ST_RANGE;
      end else begin
        val = (cur_dir == DIR_W) ? LonBase - degrees_acc : degrees_acc;
        lon_deg = val[LonW-1:0];
        lon_known = 1'b1;
      end
    end
  endtask

  // A byte that ends a number is read again as the next direction letter.
  task automatic end_number(input logic [7:0] c);
    close_angle();
    if (first_err == ST_OK && !both_known()) take_letter(c);
  endtask

  task automatic parse_byte(input logic [7:0] c);
    int unsigned t;
    case (cur_phase)
      PH_LETTER: take_letter(c);
      PH_FIRST: begin
        if (is_digit(c)) begin
          degrees_acc = AccW'(c - ChZero);
          cur_phase = PH_WHOLE;
        end else begin
          first_err = ST_NO_ANGLE;
        end
      end
      PH_WHOLE: begin
        if (is_digit(c)) begin
          t = degrees_acc * 10 + (c - ChZero);
          degrees_acc = (t > AccMax) ? AccMax : AccW'(t);
        end else if (c == ChDot || c == ChComma) begin
          cur_phase = PH_FRAC;
        end else begin
          end_number(c);
        end
      end
      default: begin
        if (!is_digit(c)) end_number(c);
      end
    endcase
  endtask

  task automatic predict_coords(input logic [7:0] c, input logic is_last);
    tfcp_result_t res;
    if (c == ChSlash || c == ChBslash) begin
      coord_clear();
    end else if (first_err == ST_OK && !both_known()) begin
      parse_byte(c);
    end
    if (is_last) begin
      if (first_err == ST_OK && !both_known()) begin
        if (cur_phase == PH_WHOLE || cur_phase == PH_FRAC) close_angle();
        if (first_err == ST_OK && !both_known()) first_err = ST_END;
      end
      res.status     = first_err;
      res.colatitude = (first_err == ST_OK) ? colat_deg : '0;
      res.longitude  = (first_err == ST_OK) ? lon_deg : '0;
      expected_coords.push_back(res);
      coord_clear();
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_coords();
    tfcp_result_t want;
    if (expected_coords.size() == 0) begin
      report_mismatch("result word with no path pending", 32'(status_i), 0);
    end else begin
      want = expected_coords.pop_front();
      if (status_i !== want.status) begin
        report_mismatch("status", 32'(status_i), 32'(want.status));
      end
      if (colatitude_i !== want.colatitude) begin
        report_mismatch("colatitude", 32'(colatitude_i), 32'(want.colatitude));
      end
      if (longitude_i !== want.longitude) begin
        report_mismatch("longitude", 32'(longitude_i), 32'(want.longitude));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_clear();
      expected_coords.delete();
    end else begin
      // The word leaving now belongs to an earlier path, so check before predicting.
      if (out_valid_i && out_ready_i) check_coords();
      if (in_valid_i && in_ready_i) predict_coords(ch_i, last_i);
    end
    pending_o    <= expected_coords.size();
    mismatches_o <= mismatch_count;
  end

endmodule

[tb/tb_tile_filename_coord_parser_unit.sv]
module tb_tile_filename_coord_parser_unit;
  import tfcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PathBytes     = 1700;
  localparam int unsigned PressureAt    = 600;
  localparam int unsigned QuietAt       = 1450;
  localparam int unsigned HoldCycles    = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 10;

  logic       clk;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] ch       = '0;
  logic       last     = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] status;
  logic [7:0] colatitude;
  logic [8:0] longitude;

  logic hold_req = 1'b0;
  logic quiet    = 1'b0;
  logic no_gap   = 1'b0;

  int unsigned coords_pending;
  int unsigned mismatches;
  int unsigned bytes_sent = 0;
  int unsigned stall_cycles;

  logic [7:0] path_q[$];

  tile_filename_coord_parser_unit dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .ch_i         (ch),
    .last_i       (last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .colatitude_o (colatitude),
    .longitude_o  (longitude)
  );

  tfcp_coord_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .ch_i         (ch),
    .last_i       (last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .status_i     (status),
    .colatitude_i (colatitude),
    .longitude_i  (longitude),
    .pending_o    (coords_pending),
    .mismatches_o (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) path_q.push_back(s[i]);
  endtask

  task automatic add_dir(input bit is_lat);
    logic [7:0] opts[4];
    if (is_lat) begin
      opts = '{ChUpN, ChLoN, ChUpS, ChLoS};
    end else begin
      opts = '{ChUpW, ChLoW, ChUpE, ChLoE};
    end
    path_q.push_back(opts[$urandom_range(0, 3)]);
  endtask

  // Angles lean toward the range limits and toward accumulator saturation.
  task automatic add_angle(input bit is_lat);
    int unsigned lim;
    int unsigned v;
    string s;
    lim = is_lat ? 90 : 359;
    case ($urandom_range(0, 9))
      0: v = lim;
      1: v = lim + 1;
      2: v = 0;
      3: v = $urandom_range(lim + 1, 99999);
      default: v = $urandom_range(0, lim);
    endcase
    s = $sformatf("%0d", v);
    if ($urandom_range(0, 7) == 0) s = {"0", s};
    push_str(s);
    if ($urandom_range(0, 2) == 0) begin
      path_q.push_back($urandom_range(0, 1) ? ChDot : ChComma);
      repeat ($urandom_range(0, 3)) path_q.push_back(8'(ChZero + $urandom_range(0, 9)));
    end
  endtask

  task automatic add_coord_pair();
    bit lat_first;
    lat_first = ($urandom_range(0, 3) != 0);
    add_dir(lat_first);
    add_angle(lat_first);
    add_dir(!lat_first);
    add_angle(!lat_first);
  endtask

  task automatic add_junk();
    repeat ($urandom_range(1, 6)) begin
      path_q.push_back($urandom_range(0, 2) ? 8'($urandom_range(8'h61, 8'h7A))
                                            : 8'(ChZero + $urandom_range(0, 9)));
    end
  endtask

  task automatic build_path();
    int unsigned kind;
    int unsigned idx;
    path_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 9) begin
      repeat ($urandom_range(1, 10)) path_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 1)) add_junk();
        else add_coord_pair();
        path_q.push_back($urandom_range(0, 1) ? ChSlash : ChBslash);
      end
      add_coord_pair();
      case ($urandom_range(0, 4))
        0: push_str(".hgt");
        1: push_str("_v2");
        2: push_str(".HGT.zip");
        3: path_q.push_back(8'($urandom_range(8'h5D, 8'hFF)));
        default: ;
      endcase
      // Broken paths: cut short, a byte replaced, a byte inserted, or a trailing separator.
      if (kind >= 7) begin
        idx = $urandom_range(0, path_q.size() - 1);
        case ($urandom_range(0, 3))
          0: while (path_q.size() > idx + 1) void'(path_q.pop_back());
          1: path_q[idx] = 8'($urandom_range(0, 255));
          2: path_q.insert(idx, 8'($urandom_range(0, 255)));
          default: path_q.push_back($urandom_range(0, 1) ? ChSlash : ChBslash);
        endcase
      end
    end
  endtask

  task automatic sender_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 7)) @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic is_last);
    in_valid <= 1'b1;
    ch       <= c;
    last     <= is_last;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_path();
    for (int i = 0; i < path_q.size(); i++) begin
      if (!quiet && !no_gap && $urandom_range(0, 9) == 0) sender_gap();
      send_byte(path_q[i], i == path_q.size() - 1);
    end
  endtask

  task automatic send_str(input string s);
    path_q.delete();
    push_str(s);
    send_path();
  endtask

  // Receiver: short random stalls, one long hold when asked, none near the end.
  initial begin
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req  <= 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tile_filename_coord_parser_unit: mismatch");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_str("X");
    send_str("s.");
    send_str("N91/");
    send_str("S90e0");
    send_str("W359,9n0");
    send_str("n1234");

    while (bytes_sent < PressureAt) begin
      build_path();
      send_path();
    end

    // Keep offering paths while the receiver holds off, so the block backs up.
    hold_req <= 1'b1;
    no_gap   <= 1'b1;
    repeat (20) begin
      build_path();
      send_path();
    end
    no_gap   <= 1'b0;
    in_valid <= 1'b0;
    // The pending count is a registered copy of the expected-result queue size.
    @(posedge clk);
    while (coords_pending != 0) @(posedge clk);

    while (bytes_sent < PathBytes) begin
      if (bytes_sent >= QuietAt) quiet <= 1'b1;
      build_path();
      send_path();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (coords_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tile_filename_coord_parser_unit: match");
    end else begin
      $display("tile_filename_coord_parser_unit: mismatch");
    end
    $finish;
  end

endmodule
